>>> rtl/kpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the key press classifier.
// No dependencies; imported by every module of the block.
package kpc_pkg;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_READ = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  // Per-key debounce phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2
  } phase_e;

  // Click codes
  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_LONG   = 2'd2
  } click_e;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACCESS,
    ST_DONE
  } ctrl_state_e;

  // Configuration register indexes
  localparam logic CFG_HOLD_TICKS    = 1'b0;
  localparam logic CFG_PRESSED_LEVEL = 1'b1;

  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned PIN_BITS   = 5;
  localparam int unsigned KEY_IDX_W  = 3;

  // One entry of the per-key state memory
  typedef struct packed {
    phase_e             phase;
    logic [HOLD_W-1:0]  hold_count;
    click_e             click_type;
    logic               unread;
    logic               long_seen;
  } key_rec_t;

  localparam key_rec_t KEY_REC_RESET = '{
    phase:      PH_IDLE,
    hold_count: '0,
    click_type: CLICK_NONE,
    unread:     1'b1,
    long_seen:  1'b0
  };

  // Click raised by one key on one tick
  typedef struct packed {
    logic   fire;
    click_e kind;
  } kpc_event_t;

endpackage

>>> rtl/kpc_key_mem.sv
`timescale 1ns / 1ps
// Per-key state memory: one write port, one registered read port.
// Entries not yet written read as the reset record. Uses kpc_pkg.
module kpc_key_mem #(
  parameter int unsigned KEYS = 5,
  parameter int unsigned KW   = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [KW-1:0]    rd_addr_i,
  output kpc_pkg::key_rec_t rd_data_o,
  input  logic             we_i,
  input  logic [KW-1:0]    wr_addr_i,
  input  kpc_pkg::key_rec_t wr_data_i
);
  import kpc_pkg::*;

  key_rec_t          mem_q [KEYS];
  logic [KEYS-1:0]   valid_q;
  key_rec_t          rd_rec_q;
  logic              rd_valid_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_rec_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits stand in for a clear of the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_rec_q : KEY_REC_RESET;

`ifndef SYNTHESIS
  // The sequencer never reads an entry in the cycle it is rewritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_i && rd_en_i && (wr_addr_i == rd_addr_i)))
    else $error("kpc_key_mem: read and write of the same entry");
  // Once written, an entry stays valid until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> valid_q[$past(wr_addr_i)])
    else $error("kpc_key_mem: written entry not marked valid");
  // A read returns the data of a written entry after the write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_i && !rd_en_i) ##1 (rd_en_i && rd_addr_i == $past(wr_addr_i) && !we_i)
      |=> rd_data_o == $past(wr_data_i, 2))
    else $error("kpc_key_mem: read data differs from written data");
`endif

endmodule

>>> rtl/kpc_key_update.sv
`timescale 1ns / 1ps
// Next state of one key on a scan tick: debounce, hold count, click detect.
// Pure combinational; uses kpc_pkg.
module kpc_key_update (
  input  kpc_pkg::key_rec_t  rec_i,
  input  logic               down_i,
  input  logic [15:0]        hold_ticks_i,
  output kpc_pkg::key_rec_t  rec_o,
  output kpc_pkg::kpc_event_t evt_o
);
  import kpc_pkg::*;

  always_comb begin
    rec_o = rec_i;
    evt_o = '{fire: 1'b0, kind: CLICK_NONE};
    unique case (rec_i.phase)
      PH_IDLE: begin
        if (down_i) begin
          rec_o.phase      = PH_DEBOUNCE;
          rec_o.hold_count = '0;
        end
      end
      PH_DEBOUNCE: begin
        rec_o.phase = down_i ? PH_PRESSED : PH_IDLE;
      end
      PH_PRESSED: begin
        if (!down_i) begin
          // release: short press only if no long click and under hold time
          if (!rec_i.long_seen && (rec_i.hold_count < hold_ticks_i)) begin
            evt_o = '{fire: 1'b1, kind: CLICK_SINGLE};
            rec_o.click_type = CLICK_SINGLE;
            rec_o.unread     = 1'b1;
          end
          rec_o.phase     = PH_IDLE;
          rec_o.long_seen = 1'b0;
        end else if (rec_i.hold_count >= hold_ticks_i) begin
          // long click, count restarts at one
          evt_o = '{fire: 1'b1, kind: CLICK_LONG};
          rec_o.click_type = CLICK_LONG;
          rec_o.unread     = 1'b1;
          rec_o.long_seen  = 1'b1;
          rec_o.hold_count = 16'd1;
        end else begin
          rec_o.hold_count = rec_i.hold_count + 16'd1;
        end
      end
      default: begin
        rec_o.phase = PH_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/key_press_classifier_unit.sv
`timescale 1ns / 1ps
// Key press classifier: per-key debounce and short/long click detection.
// Scan tick: one key per cycle through the per-key state memory, then the done
// state. Read or peek: access state, then done; unused kind or bad index: done.
// The next request is taken the cycle after a result is loaded; a stalled result
// holds up the next one.
// Reset (rst_ni low, async) resets control and config registers and per-key state.
module key_press_classifier_unit #(
  parameter int unsigned KEYS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [4:0] pin_levels, [7:5] key_index
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [1:0] click_kind, [4:2] latest_key,
                                     // [6:5] latest_kind, [7] zero
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import kpc_pkg::*;

  localparam int unsigned KW = (KEYS > 1) ? $clog2(KEYS) : 1;

  ctrl_state_e          state_q, state_d;
  kind_e                kind_q;
  logic [PIN_BITS-1:0]  levels_q;
  logic [KW-1:0]        idx_q;
  logic [KW-1:0]        cnt_q, cnt_d;
  logic [15:0]          hold_ticks_q;
  logic                 pressed_level_q;
  logic [2:0]           recent_key_q, recent_key_d;
  click_e               recent_kind_q, recent_kind_d;
  click_e               answer_q, answer_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_data_q, out_data_d;

  logic                 in_accept;
  kind_e                in_kind;
  logic [5:0]           in_idx_ext;
  logic                 in_range;
  logic                 last_key;
  logic                 out_free;
  logic [31:0]          levels_ext;
  logic                 key_down;

  logic                 rd_en;
  logic [KW-1:0]        rd_addr;
  key_rec_t             rd_data;
  logic                 we;
  logic [KW-1:0]        wr_addr;
  key_rec_t             wr_data;
  key_rec_t             upd_rec;
  kpc_event_t           upd_evt;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_kind    = kind_e'(s_axis_tuser);
  assign in_idx_ext = {3'b000, s_axis_tdata[7:5]};
  assign in_range   = in_idx_ext < 6'(KEYS);
  assign last_key   = (cnt_q == KW'(KEYS - 1));
  assign out_free   = !out_valid_q || m_axis_tready;
  assign levels_ext = {{(32 - PIN_BITS){1'b0}}, levels_q};
  assign key_down   = (levels_ext[5'(cnt_q)] == pressed_level_q);

  // Per-key state memory and update lane
  kpc_key_mem #(
    .KEYS (KEYS),
    .KW   (KW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  kpc_key_update u_upd (
    .rec_i        (rd_data),
    .down_i       (key_down),
    .hold_ticks_i (hold_ticks_q),
    .rec_o        (upd_rec),
    .evt_o        (upd_evt)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_kind == KIND_TICK) begin
            state_d = ST_SCAN;
          end else if ((in_kind == KIND_READ || in_kind == KIND_PEEK) && in_range) begin
            state_d = ST_ACCESS;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (last_key) begin
          state_d = ST_DONE;
        end
      end
      ST_ACCESS: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: memory accesses, answer, latest event, result
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = cnt_q;
    wr_data       = upd_rec;
    cnt_d         = cnt_q;
    answer_d      = answer_q;
    recent_key_d  = recent_key_q;
    recent_kind_d = recent_kind_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept) begin
          cnt_d    = '0;
          answer_d = CLICK_NONE;
          if (in_kind == KIND_TICK) begin
            rd_en = 1'b1;
          end else if ((in_kind == KIND_READ || in_kind == KIND_PEEK) && in_range) begin
            rd_en   = 1'b1;
            rd_addr = in_idx_ext[KW-1:0];
          end
        end
      end
      ST_SCAN: begin
        we      = 1'b1;
        wr_addr = cnt_q;
        wr_data = upd_rec;
        if (upd_evt.fire) begin
          recent_key_d  = 3'(cnt_q);
          recent_kind_d = upd_evt.kind;
        end
        if (!last_key) begin
          rd_en   = 1'b1;
          rd_addr = cnt_q + KW'(1);
          cnt_d   = cnt_q + KW'(1);
        end
      end
      ST_ACCESS: begin
        wr_addr = idx_q;
        wr_data = rd_data;
        wr_data.unread = 1'b0;
        if (kind_q == KIND_PEEK) begin
          answer_d = rd_data.click_type;
        end else if (rd_data.unread) begin
          answer_d = rd_data.click_type;
          we       = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, recent_kind_q, recent_key_q, answer_q};
        end
      end
      default: begin
        out_valid_d = out_valid_q && !m_axis_tready;
      end
    endcase
  end

  // Control, event and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cnt_q           <= '0;
      hold_ticks_q    <= 16'd100;
      pressed_level_q <= 1'b0;
      recent_key_q    <= '0;
      recent_kind_q   <= CLICK_NONE;
      out_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      recent_key_q  <= recent_key_d;
      recent_kind_q <= recent_kind_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HOLD_TICKS:    hold_ticks_q    <= cfg_data_i;
          CFG_PRESSED_LEVEL: pressed_level_q <= cfg_data_i[0];
          default:           hold_ticks_q    <= hold_ticks_q;
        endcase
      end
    end
  end

  // Request payload and result registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q   <= in_kind;
      levels_q <= s_axis_tdata[4:0];
      idx_q    <= in_idx_ext[KW-1:0];
    end
    answer_q   <= answer_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // A tick request always starts the key sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_kind == KIND_TICK) |=> (state_q == ST_SCAN && cnt_q == '0))
    else $error("kpc: tick did not start the sweep");
  // The sweep never addresses a key beyond the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= KW'(KEYS - 1)))
    else $error("kpc: sweep counter out of range");
  // A new result is only loaded from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && $past(out_valid_q) && $past(m_axis_tready)) |->
      $past(state_q == ST_DONE))
    else $error("kpc: result loaded outside the done state");
  // The latest event only changes during a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |=> $stable(recent_kind_q))
    else $error("kpc: latest event changed outside a sweep");
`endif

endmodule

>>> verif/tb_key_press_classifier_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of key_press_classifier_unit: a directed table, then
// random button traffic; results are checked against an in-bench debounce model.
// Depends on rtl/kpc_pkg.sv and rtl/key_press_classifier_unit.sv.
module tb_key_press_classifier_unit;
  import kpc_pkg::*;

  localparam int unsigned NUM_KEYS         = 5;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned NUM_PHASES       = 6;
  localparam logic [1:0]  KIND_UNUSED      = 2'd3;

  // Response as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic       pad;
    click_e     latest_kind;
    logic [2:0] latest_key;
    click_e     click_kind;
  } response_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;

  // One row of the directed table
  typedef struct packed {
    row_op_e    op;
    logic [1:0] kind;
    logic [4:0] pins;
    logic [2:0] idx;
    logic       reg_sel;
    logic [15:0] reg_val;
    logic       fixed;
    response_t  res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_HOLD_TICKS;
  logic [15:0] cfg_data_i = '0;

  // Typed expectation travels with the request it belongs to
  logic      drv_fixed = 1'b0;
  response_t drv_expect = '0;

  bit gaps_on = 1'b0;
  bit rx_hold_req = 1'b0;
  int mismatches = 0;

  response_t pending_clicks[$];

  // Shadow of the block: registers and per-key state
  logic [15:0] hold_shadow = 16'd100;
  logic        level_shadow = 1'b0;
  phase_e      key_phase [NUM_KEYS];
  logic [15:0] key_hold  [NUM_KEYS];
  click_e      key_click [NUM_KEYS];
  logic        key_unread [NUM_KEYS];
  logic        key_long  [NUM_KEYS];
  logic [2:0]  last_key = '0;
  click_e      last_kind = CLICK_NONE;

  always #1 clk_i = ~clk_i;

  key_press_classifier_unit #(
    .KEYS(NUM_KEYS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [4:0] pin_levels, [7:5] key_index
    .s_axis_tuser (s_axis_tuser),   // [1:0] kind
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [1:0] click_kind, [4:2] latest_key,
                                    // [6:5] latest_kind, [7] zero
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_phase[k]  = PH_IDLE;
      key_hold[k]   = '0;
      key_click[k]  = CLICK_NONE;
      key_unread[k] = 1'b1;
      key_long[k]   = 1'b0;
    end
  end

  function automatic void log_click(int k, click_e kind);
    key_click[k]  = kind;
    key_unread[k] = 1'b1;
    last_key      = k[2:0];
    last_kind     = kind;
  endfunction

  // Debounce/classify one request and return the response it should produce
  function automatic response_t classify_request(logic [1:0] kind, logic [4:0] pins,
                                                 logic [2:0] idx);
    response_t r;
    click_e    answer;
    logic      down;
    answer = CLICK_NONE;
    if (kind == KIND_TICK) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        down = (pins[k] == level_shadow);
        case (key_phase[k])
          PH_IDLE: begin
            if (down) begin
              key_phase[k] = PH_DEBOUNCE;
              key_hold[k]  = '0;
            end
          end
          PH_DEBOUNCE: begin
            key_phase[k] = down ? PH_PRESSED : PH_IDLE;
          end
          PH_PRESSED: begin
            if (!down) begin
              // release after a long click, or at hold time, is silent
              if (!key_long[k] && key_hold[k] < hold_shadow) log_click(k, CLICK_SINGLE);
              key_phase[k] = PH_IDLE;
              key_long[k]  = 1'b0;
            end else begin
              if (key_hold[k] >= hold_shadow) begin
                log_click(k, CLICK_LONG);
                key_hold[k] = '0;
                key_long[k] = 1'b1;
              end
              key_hold[k] = key_hold[k] + 16'd1;
            end
          end
          default: begin
            key_phase[k] = PH_IDLE;
          end
        endcase
      end
    end else if ((kind == KIND_READ || kind == KIND_PEEK) && idx < NUM_KEYS) begin
      if (kind == KIND_PEEK) begin
        answer = key_click[idx];
      end else if (key_unread[idx]) begin
        key_unread[idx] = 1'b0;
        answer = key_click[idx];
      end
    end
    r.pad         = 1'b0;
    r.click_kind  = answer;
    r.latest_key  = last_key;
    r.latest_kind = last_kind;
    return r;
  endfunction

  task automatic compare_field(string what, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Observe both streams and the config port at each edge
  always @(posedge clk_i) begin : monitor
    response_t got;
    response_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_clicks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = pending_clicks.pop_front();
          compare_field("click_kind", 4'(want.click_kind), 4'(got.click_kind));
          compare_field("latest_key", 4'(want.latest_key), 4'(got.latest_key));
          compare_field("latest_kind", 4'(want.latest_kind), 4'(got.latest_kind));
          compare_field("pad bit", 4'(want.pad), 4'(got.pad));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_HOLD_TICKS) hold_shadow = cfg_data_i;
        else level_shadow = cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = classify_request(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[7:5]);
        pending_clicks.push_back(drv_fixed ? drv_expect : want);
      end
    end
  end

  // Result side: short random stalls, plus one long hold-off on request
  initial begin : receiver
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(logic [1:0] kind, logic [4:0] pins, logic [2:0] idx,
                          logic fixed, response_t res);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, pins};
    s_axis_tuser  <= kind;
    drv_fixed     <= fixed;
    drv_expect    <= res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every response is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_clicks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic sel, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic row_t ask(logic [1:0] kind, logic [4:0] pins, logic [2:0] idx);
    row_t r;
    r      = '0;
    r.op   = ROW_REQ;
    r.kind = kind;
    r.pins = pins;
    r.idx  = idx;
    return r;
  endfunction

  function automatic row_t ask_sure(logic [1:0] kind, logic [4:0] pins, logic [2:0] idx,
                                    click_e click, logic [2:0] key, click_e latest);
    row_t r;
    r                 = ask(kind, pins, idx);
    r.fixed           = 1'b1;
    r.res.click_kind  = click;
    r.res.latest_key  = key;
    r.res.latest_kind = latest;
    return r;
  endfunction

  function automatic row_t reg_row(logic sel, logic [15:0] val);
    row_t r;
    r         = '0;
    r.op      = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // Stimulus: directed table, then random phases with different settings
  initial begin : stimulus
    row_t        plan[$];
    int unsigned phase_hold [NUM_PHASES] = '{1, 0, 3, 65535, 2, 5};
    bit          phase_level [NUM_PHASES] = '{0, 1, 1, 0, 0, 1};
    int          phase_len [NUM_PHASES] = '{110, 90, 110, 40, 110, 110};
    bit          run_down [NUM_KEYS];
    int          run_left [NUM_KEYS];
    int          down_max;
    int          pick;
    logic [4:0]  pins;
    logic [2:0]  idx;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'b1;

    // Reset defaults: hold 100, pins low mean pressed
    plan.push_back(ask_sure(KIND_READ, 5'h1F, 3'd0, CLICK_NONE, 3'd0, CLICK_NONE));
    plan.push_back(ask_sure(KIND_READ, 5'h1F, 3'd0, CLICK_NONE, 3'd0, CLICK_NONE));
    plan.push_back(ask_sure(KIND_PEEK, 5'h1F, 3'd4, CLICK_NONE, 3'd0, CLICK_NONE));
    plan.push_back(ask_sure(KIND_READ, 5'h1F, 3'd7, CLICK_NONE, 3'd0, CLICK_NONE));
    plan.push_back(ask_sure(KIND_UNUSED, 5'h1F, 3'd2, CLICK_NONE, 3'd0, CLICK_NONE));
    // all keys pressed briefly: single clicks, key 4 is reported last
    plan.push_back(ask(KIND_TICK, 5'h00, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h00, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h00, 3'd0));
    plan.push_back(ask_sure(KIND_TICK, 5'h1F, 3'd0, CLICK_NONE, 3'd4, CLICK_SINGLE));
    plan.push_back(ask_sure(KIND_READ, 5'h1F, 3'd4, CLICK_SINGLE, 3'd4, CLICK_SINGLE));
    plan.push_back(ask_sure(KIND_PEEK, 5'h1F, 3'd4, CLICK_SINGLE, 3'd4, CLICK_SINGLE));
    plan.push_back(ask_sure(KIND_READ, 5'h1F, 3'd4, CLICK_NONE, 3'd4, CLICK_SINGLE));
    // zero hold time: long click as soon as the press is debounced
    plan.push_back(reg_row(CFG_HOLD_TICKS, 16'd0));
    plan.push_back(ask(KIND_TICK, 5'h1E, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h1E, 3'd0));
    plan.push_back(ask_sure(KIND_TICK, 5'h1E, 3'd0, CLICK_NONE, 3'd0, CLICK_LONG));
    plan.push_back(ask(KIND_TICK, 5'h1E, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h1F, 3'd0));
    // active-high pins; release exactly at hold time gives nothing
    plan.push_back(reg_row(CFG_PRESSED_LEVEL, 16'd1));
    plan.push_back(reg_row(CFG_HOLD_TICKS, 16'd2));
    plan.push_back(ask(KIND_TICK, 5'h01, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h01, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h01, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h01, 3'd0));
    plan.push_back(ask_sure(KIND_TICK, 5'h00, 3'd0, CLICK_NONE, 3'd0, CLICK_LONG));
    // maximum hold time
    plan.push_back(reg_row(CFG_HOLD_TICKS, 16'hFFFF));
    plan.push_back(ask(KIND_TICK, 5'h08, 3'd0));
    plan.push_back(ask(KIND_TICK, 5'h08, 3'd0));
    plan.push_back(ask_sure(KIND_TICK, 5'h00, 3'd0, CLICK_NONE, 3'd3, CLICK_SINGLE));
    plan.push_back(ask_sure(KIND_READ, 5'h00, 3'd3, CLICK_SINGLE, 3'd3, CLICK_SINGLE));

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send_req(plan[i].kind, plan[i].pins, plan[i].idx, plan[i].fixed, plan[i].res);
      end
    end

    // Random phases: per-key press/release runs sized around the hold time, at most 40 ticks down
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_HOLD_TICKS, phase_hold[p][15:0]);
      write_reg(CFG_PRESSED_LEVEL, {15'd0, phase_level[p]});
      if (p == NUM_PHASES - 1) gaps_on = 1'b0;
      down_max = (phase_hold[p] >= 18) ? 40 : 2 * phase_hold[p] + 4;
      for (int k = 0; k < NUM_KEYS; k++) begin
        run_down[k] = 1'b0;
        run_left[k] = $urandom_range(0, 3);
      end
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 2 && n == 50) rx_hold_req = 1'b1;
        if (p == 4 && n == 55) drain();
        pick = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        if (pick < 64) begin
          for (int k = 0; k < NUM_KEYS; k++) begin
            if (run_left[k] == 0) begin
              run_down[k] = ~run_down[k];
              run_left[k] = run_down[k] ? $urandom_range(1, down_max) : $urandom_range(1, 6);
            end
            run_left[k]--;
            pins[k] = run_down[k] ? phase_level[p] : ~phase_level[p];
          end
          send_req(KIND_TICK, pins, 3'($urandom_range(0, 7)), 1'b0, '0);
        end else if (pick < 76) begin
          send_req(KIND_READ, 5'($urandom_range(0, 31)), idx, 1'b0, '0);
        end else if (pick < 88) begin
          send_req(KIND_PEEK, 5'($urandom_range(0, 31)), idx, 1'b0, '0);
        end else if (pick < 94) begin
          // glitchy pins, off the run pattern
          send_req(KIND_TICK, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                   1'b0, '0);
        end else begin
          send_req(KIND_UNUSED, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                   1'b0, '0);
        end
      end
    end

    drain();
    repeat (2 * NUM_KEYS + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_clicks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kpc_pkg.sv
rtl/kpc_key_mem.sv
rtl/kpc_key_update.sv
rtl/key_press_classifier_unit.sv
verif/tb_key_press_classifier_unit.sv
